@@ rtl/reliable_udp_ack_tracker_defines.svh @@
// Assertion macros for the reliable UDP ack tracker checker.
// No dependencies; included by the checker file.
`ifndef RELIABLE_UDP_ACK_TRACKER_DEFINES_SVH
`define RELIABLE_UDP_ACK_TRACKER_DEFINES_SVH

// ante implies cons in the same cycle
`define RUTRK_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// ante implies cons in the next cycle
`define RUTRK_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/rutrk_pkg.sv @@
// Shared types and codes for the reliable UDP ack tracker.
// No dependencies.
package rutrk_pkg;

	typedef enum logic [1:0] {
		REG_EXP_PROTO     = 2'd0,
		REG_SEND_INTERVAL = 2'd1,
		REG_TIMEOUT       = 2'd2
	} cfg_reg_t;

	localparam logic KIND_SEND       = 1'b0;
	localparam logic KIND_DISCONNECT = 1'b1;

	localparam logic ACTION_TICK   = 1'b0;
	localparam logic ACTION_PACKET = 1'b1;

	localparam int CFG_WIDTH = 32;
	localparam int CFG_INDEX_WIDTH = 2;
	localparam logic [CFG_WIDTH-1:0] SEND_INTERVAL_RST = 32'd1000;
	localparam logic [CFG_WIDTH-1:0] TIMEOUT_RST       = 32'd5000;

	localparam int RES_DEPTH = 4;

	typedef struct packed {
		logic        action;
		logic [31:0] packet_protocol;
		logic [31:0] packet_sequence;
		logic [31:0] sender_address;
		logic [15:0] sender_port;
	} in_item_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] dest_address;
		logic [15:0] dest_port;
		logic [31:0] out_sequence;
		logic [31:0] ack_sequence;
		logic [31:0] ack_mask;
		logic        last;
	} res_item_t;

	// results of one tick, in delivery order
	typedef struct packed {
		logic [1:0] count;
		res_item_t  first;
		res_item_t  second;
	} res_pair_t;

endpackage

@@ rtl/rutrk_stream_if.sv @@
// Valid/ready stream interface carrying one payload type.
// Used with the payload structs of rutrk_pkg.
interface rutrk_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/rutrk_ack_window.sv @@
// Remote sequence and ack bitfield update for one accepted packet.
// Depends on nothing but its parameter.
module rutrk_ack_window #(
	parameter int ACK_WIDTH = 32
) (
	input  logic [31:0]          remote_seq,
	input  logic [ACK_WIDTH-1:0] ack_field,
	input  logic [31:0]          seq,
	output logic [31:0]          remote_seq_nx,
	output logic [ACK_WIDTH-1:0] ack_field_nx
);
	localparam int SW = $clog2(ACK_WIDTH);

	logic [31:0]          diff;
	logic [31:0]          back;
	logic                 newer;
	logic [ACK_WIDTH-1:0] shifted;
	logic [ACK_WIDTH-1:0] own;

	always_comb begin
		newer = seq > remote_seq;
		diff = seq - remote_seq;
		if (!newer) begin
			shifted = ack_field;
			remote_seq_nx = remote_seq;
		end else begin
			remote_seq_nx = seq;
			if (diff >= 32'(ACK_WIDTH))
				shifted = '0;
			else
				shifted = ack_field << diff[SW-1:0];
		end
		back = remote_seq_nx - seq;
		if (back < 32'(ACK_WIDTH))
			own = ACK_WIDTH'(1) << back[SW-1:0];
		else
			own = '0;
		ack_field_nx = shifted | own;
	end
endmodule

@@ rtl/rutrk_core.sv @@
// Connection state, timers and per-tick result generation.
// Depends on rutrk_pkg and rutrk_ack_window.
module rutrk_core
	import rutrk_pkg::*;
#(
	parameter int ACK_WIDTH = 32,
	parameter int TIMER_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  in_item_t             item,
	input  logic [CFG_WIDTH-1:0] exp_proto,
	input  logic [CFG_WIDTH-1:0] send_interval,
	input  logic [CFG_WIDTH-1:0] timeout_ticks,
	output res_pair_t            results
);
	localparam int CW = (TIMER_WIDTH > CFG_WIDTH) ? TIMER_WIDTH : CFG_WIDTH;
	localparam int MW = (ACK_WIDTH > 32) ? ACK_WIDTH : 32;

	logic                   connected_q, connected_nx;
	logic [31:0]            client_addr_q, client_addr_nx;
	logic [15:0]            client_port_q, client_port_nx;
	logic [31:0]            local_seq_q, local_seq_nx;
	logic [31:0]            remote_seq_q, remote_seq_nx;
	logic [ACK_WIDTH-1:0]   ack_q, ack_nx;
	logic [TIMER_WIDTH-1:0] since_sent_q, since_sent_nx;
	logic [TIMER_WIDTH-1:0] since_recv_q, since_recv_nx;

	logic [31:0]          win_remote;
	logic [ACK_WIDTH-1:0] win_ack;
	logic                 match;
	logic                 do_send;
	logic                 do_disc;
	logic [MW-1:0]        ack_ext;
	res_item_t            send_res;
	res_item_t            disc_res;

	rutrk_ack_window #(.ACK_WIDTH(ACK_WIDTH)) u_win (
		.remote_seq   (remote_seq_q),
		.ack_field    (ack_q),
		.seq          (item.packet_sequence),
		.remote_seq_nx(win_remote),
		.ack_field_nx (win_ack)
	);

	always_comb begin
		since_sent_nx = (since_sent_q == '1) ? since_sent_q : since_sent_q + 1'b1;
		since_recv_nx = (since_recv_q == '1) ? since_recv_q : since_recv_q + 1'b1;
		connected_nx = connected_q;
		client_addr_nx = client_addr_q;
		client_port_nx = client_port_q;
		local_seq_nx = local_seq_q;
		remote_seq_nx = remote_seq_q;
		ack_nx = ack_q;

		match = (item.action == ACTION_PACKET) && (item.packet_protocol == exp_proto);
		if (match) begin
			since_recv_nx = '0;
			if (connected_q) begin
				remote_seq_nx = win_remote;
				ack_nx = win_ack;
			end else begin
				connected_nx = 1'b1;
				client_addr_nx = item.sender_address;
				client_port_nx = item.sender_port;
				remote_seq_nx = '0;
				ack_nx = '0;
			end
		end

		do_send = connected_nx && (CW'(since_sent_nx) > CW'(send_interval));
		do_disc = connected_nx && (CW'(since_recv_nx) > CW'(timeout_ticks));

		ack_ext = MW'(ack_nx);
		send_res.kind = KIND_SEND;
		send_res.dest_address = client_addr_nx;
		send_res.dest_port = client_port_nx;
		send_res.out_sequence = local_seq_q;
		send_res.ack_sequence = remote_seq_nx;
		send_res.ack_mask = ack_ext[31:0];
		send_res.last = !do_disc;

		disc_res.kind = KIND_DISCONNECT;
		disc_res.dest_address = client_addr_nx;
		disc_res.dest_port = client_port_nx;
		disc_res.out_sequence = '0;
		disc_res.ack_sequence = '0;
		disc_res.ack_mask = '0;
		disc_res.last = 1'b1;

		if (do_send) begin
			local_seq_nx = local_seq_q + 32'd1;
			since_sent_nx = '0;
		end
		if (do_disc)
			connected_nx = 1'b0;

		results.count = 2'(do_send) + 2'(do_disc);
		results.first = do_send ? send_res : disc_res;
		results.second = disc_res;
		if (!en)
			results.count = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			connected_q <= 1'b0;
			client_addr_q <= '0;
			client_port_q <= '0;
			local_seq_q <= '0;
			remote_seq_q <= '0;
			ack_q <= '0;
			since_sent_q <= '0;
			since_recv_q <= '0;
		end else if (en) begin
			connected_q <= connected_nx;
			client_addr_q <= client_addr_nx;
			client_port_q <= client_port_nx;
			local_seq_q <= local_seq_nx;
			remote_seq_q <= remote_seq_nx;
			ack_q <= ack_nx;
			since_sent_q <= since_sent_nx;
			since_recv_q <= since_recv_nx;
		end
	end
endmodule

@@ rtl/rutrk_res_fifo.sv @@
// Result queue: takes up to two results per cycle, delivers one per cycle while the result channel is ready.
// Depends on rutrk_pkg and rutrk_stream_if.
module rutrk_res_fifo
	import rutrk_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  res_pair_t push,
	output logic      room,
	rutrk_stream_if.source result
);
	localparam int PW = $clog2(RES_DEPTH);
	localparam int CNTW = $clog2(RES_DEPTH + 1);

	res_item_t       mem [RES_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CNTW-1:0] count_q;
	logic            pop;

	assign pop = result.valid && result.ready;
	assign result.valid = count_q != '0;
	assign result.payload = mem[rd_ptr_q];
	assign room = count_q <= CNTW'(RES_DEPTH - 2);

	always_ff @(posedge clk) begin
		if (push.count != 2'd0)
			mem[wr_ptr_q] <= push.first;
		if (push.count == 2'd2)
			mem[wr_ptr_q + 1'b1] <= push.second;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PW'(push.count);
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + CNTW'(push.count) - CNTW'(pop);
		end
	end
endmodule

@@ rtl/reliable_udp_ack_tracker.sv @@
// Reliable UDP ack tracker: one tick per request; each tick may emit a send
// command, a disconnect, or both, and a send comes first. A tick is accepted every
// cycle while no more than two results wait in the four-entry result queue. The tick
// is held in the input register and its results are written to the result queue, then
// leave one per cycle while the result channel is ready; rutrk_core updates per tick.
module reliable_udp_ack_tracker
	import rutrk_pkg::*;
#(
	parameter int ACK_WIDTH = 32,
	parameter int TIMER_WIDTH = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [CFG_WIDTH-1:0]       cfg_data,
	rutrk_stream_if.sink               item,
	rutrk_stream_if.source             result
);
	logic [CFG_WIDTH-1:0] exp_proto_q;
	logic [CFG_WIDTH-1:0] send_interval_q;
	logic [CFG_WIDTH-1:0] timeout_q;

	logic      valid_s1;
	in_item_t  item_s1;
	logic      room;
	logic      adv;
	res_pair_t results;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_proto_q <= '0;
			send_interval_q <= SEND_INTERVAL_RST;
			timeout_q <= TIMEOUT_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_EXP_PROTO: exp_proto_q <= cfg_data;
				REG_SEND_INTERVAL: send_interval_q <= cfg_data;
				REG_TIMEOUT: timeout_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign adv = valid_s1 && room;
	assign item.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (item.ready)
			valid_s1 <= item.valid;
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready)
			item_s1 <= item.payload;
	end

	rutrk_core #(.ACK_WIDTH(ACK_WIDTH), .TIMER_WIDTH(TIMER_WIDTH)) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (adv),
		.item         (item_s1),
		.exp_proto    (exp_proto_q),
		.send_interval(send_interval_q),
		.timeout_ticks(timeout_q),
		.results      (results)
	);

	rutrk_res_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (results),
		.room  (room),
		.result(result)
	);
endmodule

@@ rtl/rutrk_checker.sv @@
// Port-level checks for the reliable UDP ack tracker, bound to the top level.
// Depends on reliable_udp_ack_tracker_defines.svh.
`include "reliable_udp_ack_tracker_defines.svh"

module rutrk_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        out_kind,
	input logic        out_last,
	input logic [31:0] out_sequence,
	input logic [31:0] ack_sequence,
	input logic [31:0] ack_mask,
	input logic [31:0] dest_address
);
	`RUTRK_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_kind) && $stable(out_sequence) && $stable(dest_address), "stalled result changed")
	`RUTRK_ASSERT_IMP(a_disc_last, clk, arst_n, out_valid && out_kind, out_last, "disconnect not last")
	`RUTRK_ASSERT_IMP(a_disc_zero, clk, arst_n, out_valid && out_kind, out_sequence == 32'd0 && ack_sequence == 32'd0 && ack_mask == 32'd0, "disconnect fields not zero")
	`RUTRK_ASSERT_IMP(a_nonlast_send, clk, arst_n, out_valid && !out_last, !out_kind, "non-final result is not a send")
endmodule

bind reliable_udp_ack_tracker rutrk_checker u_rutrk_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.out_kind    (result.payload.kind),
	.out_last    (result.payload.last),
	.out_sequence(result.payload.out_sequence),
	.ack_sequence(result.payload.ack_sequence),
	.ack_mask    (result.payload.ack_mask),
	.dest_address(result.payload.dest_address)
);

@@ tb/reliable_udp_ack_tracker_tb.sv @@
// Self-checking testbench for reliable_udp_ack_tracker: random valid/ready traffic on both
// channels, register settings swept between phases, results checked against a local predictor.
// Depends on rutrk_pkg, rutrk_stream_if and the tracker RTL.
module reliable_udp_ack_tracker_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rutrk_pkg::*;

	localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED = 2'd3;
	localparam int ACK_BITS = 32;
	localparam int SETTLE_CYCLES = 10;
	localparam int LONG_STALL = 300;
	localparam int MAX_REPORTS = 10;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index;
	logic [CFG_WIDTH-1:0] cfg_data;

	rutrk_stream_if #(.T(in_item_t)) item_if ();
	rutrk_stream_if #(.T(res_item_t)) res_if ();

	reliable_udp_ack_tracker u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item(item_if),
		.result(res_if)
	);

	// predictor state and register copy
	logic        conn = 1'b0;
	logic [31:0] cl_addr = '0;
	logic [15:0] cl_port = '0;
	logic [31:0] loc_seq = '0;
	logic [31:0] rem_seq = '0;
	logic [31:0] acks = '0;
	logic [31:0] t_sent = '0;
	logic [31:0] t_recv = '0;
	logic [31:0] cfg_proto = '0;
	logic [31:0] cfg_interval = SEND_INTERVAL_RST;
	logic [31:0] cfg_timeout = TIMEOUT_RST;

	in_item_t  tick_queue[$];
	res_item_t due_results[$];

	int send_idle_pct = 28;
	int recv_idle_pct = 55;
	int stall_requests = 0;
	int stall_served = 0;
	int stall_left = 0;
	logic item_taken = 1'b0;

	int mismatches = 0;
	int ticks_done = 0;
	int sends_seen = 0;
	int drops_seen = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#400us;
		$display("reliable_udp_ack_tracker: mismatch");
		$finish;
	end

	function automatic void advance_tracker(input in_item_t it);
		res_item_t r[2];
		int n;
		logic [31:0] gap;
		n = 0;
		if (t_sent != '1) t_sent = t_sent + 1;
		if (t_recv != '1) t_recv = t_recv + 1;
		if (it.action == ACTION_PACKET && it.packet_protocol == cfg_proto) begin
			if (it.packet_sequence > rem_seq) begin
				gap = it.packet_sequence - rem_seq;
				acks = (gap >= ACK_BITS) ? '0 : acks << gap;
				rem_seq = it.packet_sequence;
			end
			gap = rem_seq - it.packet_sequence;
			if (gap < ACK_BITS) acks[gap[4:0]] = 1'b1;
			if (!conn) begin
				cl_addr = it.sender_address;
				cl_port = it.sender_port;
				conn = 1'b1;
				rem_seq = '0;
				acks = '0;
			end
			t_recv = '0;
		end
		if (conn) begin
			if (t_sent > cfg_interval) begin
				r[n].kind = KIND_SEND;
				r[n].dest_address = cl_addr;
				r[n].dest_port = cl_port;
				r[n].out_sequence = loc_seq;
				r[n].ack_sequence = rem_seq;
				r[n].ack_mask = acks;
				r[n].last = 1'b0;
				n++;
				loc_seq = loc_seq + 1;
				t_sent = '0;
			end
			if (t_recv > cfg_timeout) begin
				r[n].kind = KIND_DISCONNECT;
				r[n].dest_address = cl_addr;
				r[n].dest_port = cl_port;
				r[n].out_sequence = '0;
				r[n].ack_sequence = '0;
				r[n].ack_mask = '0;
				r[n].last = 1'b0;
				n++;
				conn = 1'b0;
			end
		end
		if (n > 0) r[n-1].last = 1'b1;
		for (int i = 0; i < n; i++) due_results.push_back(r[i]);
	endfunction

	// request driver
	always @(negedge clk) begin
		if (!arst_n) begin
			item_if.valid <= 1'b0;
			item_if.payload <= '0;
		end else if (!item_if.valid || item_taken) begin
			if (tick_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				item_if.payload <= tick_queue.pop_front();
				item_if.valid <= 1'b1;
			end else begin
				item_if.valid <= 1'b0;
			end
		end
	end

	// result receiver, with long hold-offs on request
	always @(negedge clk) begin
		if (stall_served != stall_requests) begin
			stall_served <= stall_served + 1;
			stall_left <= LONG_STALL;
			res_if.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			res_if.ready <= 1'b0;
		end else begin
			res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// monitor: predict on accepted requests, check accepted results
	always @(posedge clk) begin
		res_item_t want;
		res_item_t got;
		item_taken <= item_if.valid && item_if.ready;
		if (res_if.valid && res_if.ready) begin
			got = res_if.payload;
			if (due_results.size() == 0) begin
				if (mismatches < MAX_REPORTS)
					$display("%0t: unexpected result kind=%0d seq=%h", $realtime, got.kind,
						got.out_sequence);
				mismatches++;
			end else begin
				want = due_results.pop_front();
				if (got.kind !== want.kind || got.dest_address !== want.dest_address ||
					got.dest_port !== want.dest_port || got.out_sequence !== want.out_sequence ||
					got.ack_sequence !== want.ack_sequence || got.ack_mask !== want.ack_mask ||
					got.last !== want.last) begin
					if (mismatches < MAX_REPORTS) begin
						$display("%0t: exp kind=%0d addr=%h port=%h seq=%h ack=%h mask=%h last=%0d",
							$realtime, want.kind, want.dest_address, want.dest_port,
							want.out_sequence, want.ack_sequence, want.ack_mask, want.last);
						$display("%0t: got kind=%0d addr=%h port=%h seq=%h ack=%h mask=%h last=%0d",
							$realtime, got.kind, got.dest_address, got.dest_port,
							got.out_sequence, got.ack_sequence, got.ack_mask, got.last);
					end
					mismatches++;
				end
				if (got.kind == KIND_SEND) sends_seen++;
				else drops_seen++;
			end
		end
		if (item_if.valid && item_if.ready) begin
			advance_tracker(item_if.payload);
			ticks_done++;
		end
	end

	function automatic in_item_t pkt_item(input logic [31:0] proto, input logic [31:0] seq);
		in_item_t it;
		it.action = ACTION_PACKET;
		it.packet_protocol = proto;
		it.packet_sequence = seq;
		it.sender_address = $urandom;
		it.sender_port = 16'($urandom);
		return it;
	endfunction

	function automatic in_item_t noise_tick();
		in_item_t it;
		it.action = ACTION_TICK;
		it.packet_protocol = $urandom;
		it.packet_sequence = $urandom;
		it.sender_address = $urandom;
		it.sender_port = 16'($urandom);
		return it;
	endfunction

	task automatic wait_drained();
		@(negedge clk);
		while (tick_queue.size() != 0 || item_if.valid || due_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_EXP_PROTO: cfg_proto = val;
			REG_SEND_INTERVAL: cfg_interval = val;
			REG_TIMEOUT: cfg_timeout = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic set_regs(input logic [31:0] proto, input logic [31:0] interval,
		input logic [31:0] tmo, input int s_idle, input int r_idle);
		wait_drained();
		write_reg(REG_EXP_PROTO, proto);
		write_reg(REG_SEND_INTERVAL, interval);
		write_reg(REG_TIMEOUT, tmo);
		@(posedge clk);
		send_idle_pct = s_idle;
		recv_idle_pct = r_idle;
	endtask

	// mostly in-order packets on the expected protocol, with stale, jumping and foreign traffic mixed in
	task automatic fill_traffic(input int count, input logic [31:0] seq_start);
		logic [31:0] sq;
		logic [31:0] bad;
		int k;
		int r;
		int len;
		sq = seq_start;
		k = 0;
		while (k < count) begin
			r = $urandom_range(99);
			if (r < 55) begin
				sq = sq + $urandom_range(1, 3);
				tick_queue.push_back(pkt_item(cfg_proto, sq));
			end else if (r < 62) begin
				tick_queue.push_back(pkt_item(cfg_proto, sq - $urandom_range(0, 40)));
			end else if (r < 66) begin
				sq = sq + $urandom_range(30, 200);
				tick_queue.push_back(pkt_item(cfg_proto, sq));
			end else if (r < 68) begin
				tick_queue.push_back(pkt_item(cfg_proto, $urandom));
			end else if (r < 80) begin
				tick_queue.push_back(noise_tick());
			end else if (r < 88) begin
				bad = cfg_proto ^ ($urandom | (32'h1 << $urandom_range(31)));
				tick_queue.push_back(pkt_item(bad, $urandom));
			end else begin
				len = $urandom_range(2, 25);
				repeat (len) tick_queue.push_back(noise_tick());
				k += len - 1;
			end
			k++;
		end
	endtask

	initial begin
		in_item_t it;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_reg(REG_UNUSED, 32'hDEAD_BEEF);
		set_regs(32'hFFFF_FFFF, 32'd0, 32'd2, 28, 55);

		// directed: window edges, big jumps, wrap, double result on one tick, reconnect
		it = '{ACTION_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF};
		tick_queue.push_back(it);
		it = '{ACTION_PACKET, 32'h0, 32'h5, 32'h1111_2222, 16'h3333};
		tick_queue.push_back(it);
		it = '{ACTION_PACKET, 32'hFFFF_FFFF, 32'h5, 32'hFFFF_FFFF, 16'hFFFF};
		tick_queue.push_back(it);
		tick_queue.push_back(pkt_item(32'hFFFF_FFFF, 32'd0));
		tick_queue.push_back(pkt_item(32'hFFFF_FFFF, 32'd1));
		tick_queue.push_back(pkt_item(32'hFFFF_FFFF, 32'd3));
		tick_queue.push_back(pkt_item(32'hFFFF_FFFF, 32'd2));
		tick_queue.push_back(pkt_item(32'hFFFF_FFFF, 32'd40));
		tick_queue.push_back(pkt_item(32'hFFFF_FFFF, 32'd8));
		tick_queue.push_back(pkt_item(32'hFFFF_FFFF, 32'd9));
		tick_queue.push_back(pkt_item(32'hFFFF_FFFF, 32'd41));
		tick_queue.push_back(pkt_item(32'hFFFF_FFFF, 32'hFFFF_FFFF));
		tick_queue.push_back(pkt_item(32'hFFFF_FFFF, 32'd0));
		repeat (4) tick_queue.push_back(noise_tick());
		it = '{ACTION_PACKET, 32'hFFFF_FFFF, 32'h7, 32'h0, 16'h0};
		tick_queue.push_back(it);
		tick_queue.push_back(pkt_item(32'hFFFF_FFFF, 32'd8));
		repeat (3) tick_queue.push_back(noise_tick());

		set_regs($urandom, 32'd1, 32'd12, 28, 55);
		fill_traffic(200, $urandom_range(0, 1000));

		set_regs(32'h0, 32'd0, 32'd0, 28, 55);
		fill_traffic(60, $urandom);

		set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd6, 55, 28);
		fill_traffic(80, $urandom_range(0, 100));

		set_regs($urandom, 32'd3, 32'hFFFF_FFFF, 55, 28);
		fill_traffic(150, 32'hFFFF_FF00 + $urandom_range(0, 200));

		set_regs($urandom, 32'd0, 32'd20, 0, 0);
		fill_traffic(260, $urandom);
		repeat (40) @(posedge clk);
		stall_requests++;

		wait_drained();
		$display("covered %0d ticks over 6 register settings and three handshake mixes:",
			ticks_done);
		$display("%0d send commands and %0d disconnects checked", sends_seen, drops_seen);
		if (mismatches == 0 && due_results.size() == 0) begin
			$display("reliable_udp_ack_tracker: match");
		end else begin
			$display("reliable_udp_ack_tracker: mismatch");
		end
		$finish;
	end

endmodule
